[rtl/slb_pkg.sv]
`timescale 1ns / 1ps

package slb_pkg;

  // default sizing for the pending length and the byte position counters
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  // result buffer
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // fixed widths of the result fields
  localparam int OFFSET_W = 32;
  localparam int OUTLEN_W = 16;
  localparam int LINE_W   = 32;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_INT,
    MODE_MINUS,
    MODE_IDENT,
    MODE_ERROR
  } mode_t;

  localparam logic [2:0] KIND_OP      = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_STRING  = 3'd2;
  localparam logic [2:0] KIND_INT     = 3'd3;
  localparam logic [2:0] KIND_IDENT   = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic [1:0] ERR_NONE           = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN        = 2'd1;
  localparam logic [1:0] ERR_STRING_END     = 2'd2;
  localparam logic [1:0] ERR_STRING_NEWLINE = 2'd3;

  // keyword match progress on the current identifier
  localparam logic [1:0] KP_NONE = 2'd0;
  localparam logic [1:0] KP_V    = 2'd1;
  localparam logic [1:0] KP_VA   = 2'd2;
  localparam logic [1:0] KP_VAR  = 2'd3;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_V       = 8'h76;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_R       = 8'h72;

  typedef struct packed {
    logic [2:0]          token_kind;
    logic [OFFSET_W-1:0] start_offset;
    logic [OUTLEN_W-1:0] token_length;
    logic [LINE_W-1:0]   start_line;
    logic [7:0]          first_byte;
    logic [1:0]          error_code;
    logic                last_of_run;
  } token_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACK) ||
           (b == CH_RBRACK) || (b == CH_LPAREN) || (b == CH_RPAREN) ||
           (b == CH_EQUAL)  || (b == CH_SEMI)   || (b == CH_DOT);
  endfunction

endpackage

[rtl/script_lexer_byte_stream_unit.sv]
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// -------  ---  -----------------  -------------------------------------------------
// s        in   s_tvalid/s_tready  s_tdata source byte, s_tlast end of input
// m        out  m_tvalid/m_tready  m_tdata token fields, m_tuser kind, m_tlast last
//
// one source word is taken per cycle when s_tready is high; the lexer state updates in
// the same cycle and its tokens (zero, one or two) land in a four-entry result buffer
// s_tready is high while the buffer has at least two free entries, so a stalled output side
// stops input after three or four tokens have queued up
// rst (synchronous) returns the lexer to idle at offset 0, line 1 and
// empties the buffer

module script_lexer_byte_stream_unit #(
  parameter int LENGTH_BITS   = slb_pkg::LENGTH_BITS_DEF,
  parameter int POSITION_BITS = slb_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // start_offset, token_length, start_line, first_byte,
                                 // error_code, zero fill
  output logic [2:0]  m_tuser,   // token_kind
  output logic        m_tlast    // last_of_run
);

  logic            step;
  logic [1:0]      res_count;
  slb_pkg::token_t res0, res1, head;
  logic            room;

  // a word is taken only when its tokens are sure to fit
  assign s_tready = room;
  assign step     = s_tvalid && s_tready;

  slb_lexer #(
    .LENGTH_BITS   (LENGTH_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (s_tdata),
    .end_of_input (s_tlast),
    .res_count    (res_count),
    .res0         (res0),
    .res1         (res1)
  );

  // result register stage, decouples the output stall from the input side
  slb_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_count (res_count),
    .wr0      (res0),
    .wr1      (res1),
    .room     (room),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (head)
  );

  assign m_tdata = {6'b000000, head.error_code, head.first_byte, head.start_line,
                    head.token_length, head.start_offset};
  assign m_tuser = head.token_kind;
  assign m_tlast = head.last_of_run;

endmodule

[rtl/slb_lexer.sv]
`timescale 1ns / 1ps

module slb_lexer #(
  parameter int LENGTH_BITS   = slb_pkg::LENGTH_BITS_DEF,
  parameter int POSITION_BITS = slb_pkg::POSITION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      in_byte,
  input  logic            end_of_input,
  output logic [1:0]      res_count,
  output slb_pkg::token_t res0,
  output slb_pkg::token_t res1
);

  localparam int LEN_W = (LENGTH_BITS > slb_pkg::OUTLEN_W) ? slb_pkg::OUTLEN_W : LENGTH_BITS;

  slb_pkg::mode_t            mode, mode_next;
  logic [POSITION_BITS-1:0]  pos, pos_next;
  logic [slb_pkg::LINE_W-1:0] line, line_next;
  logic [POSITION_BITS-1:0]  pend_start, pend_start_next;
  logic [LEN_W-1:0]          pend_len, pend_len_next;
  logic [slb_pkg::LINE_W-1:0] pend_line, pend_line_next;
  logic [7:0]                pend_first, pend_first_next;
  logic [1:0]                kprog, kprog_next;

  logic [LEN_W-1:0]          len_inc;
  logic                      a_v, b_v, from_idle;
  slb_pkg::token_t           tok_a, tok_b;

  function automatic slb_pkg::token_t make_tok(
    input logic [2:0]                    kind,
    input logic [slb_pkg::OFFSET_W-1:0]  start,
    input logic [slb_pkg::OUTLEN_W-1:0]  len,
    input logic [slb_pkg::LINE_W-1:0]    ln,
    input logic [7:0]                    first,
    input logic [1:0]                    err
  );
    slb_pkg::token_t t;
    t.token_kind   = kind;
    t.start_offset = start;
    t.token_length = len;
    t.start_line   = ln;
    t.first_byte   = first;
    t.error_code   = err;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= slb_pkg::MODE_IDLE;
      pos        <= '0;
      line       <= slb_pkg::LINE_W'(1);
      pend_start <= '0;
      pend_len   <= '0;
      pend_line  <= slb_pkg::LINE_W'(1);
      pend_first <= '0;
      kprog      <= slb_pkg::KP_NONE;
    end else begin
      mode       <= mode_next;
      pos        <= pos_next;
      line       <= line_next;
      pend_start <= pend_start_next;
      pend_len   <= pend_len_next;
      pend_line  <= pend_line_next;
      pend_first <= pend_first_next;
      kprog      <= kprog_next;
    end
  end

  // saturating growth of the pending token
  assign len_inc = (pend_len == '1) ? pend_len : pend_len + LEN_W'(1);

  always_comb begin
    mode_next       = mode;
    pos_next        = pos;
    line_next       = line;
    pend_start_next = pend_start;
    pend_len_next   = pend_len;
    pend_line_next  = pend_line;
    pend_first_next = pend_first;
    kprog_next      = kprog;
    a_v             = 1'b0;
    b_v             = 1'b0;
    from_idle       = 1'b0;
    tok_a           = '0;
    tok_b           = '0;

    if (step) begin
      if (end_of_input) begin
        // flush the pending token, then the end marker
        unique case (mode)
          slb_pkg::MODE_STRING: begin
            a_v   = 1'b1;
            tok_a = make_tok(slb_pkg::KIND_ERROR, slb_pkg::OFFSET_W'(pend_start),
                             slb_pkg::OUTLEN_W'(pend_len), pend_line, pend_first,
                             slb_pkg::ERR_STRING_END);
          end
          slb_pkg::MODE_INT: begin
            a_v   = 1'b1;
            tok_a = make_tok(slb_pkg::KIND_INT, slb_pkg::OFFSET_W'(pend_start),
                             slb_pkg::OUTLEN_W'(pend_len), pend_line, pend_first,
                             slb_pkg::ERR_NONE);
          end
          slb_pkg::MODE_MINUS: begin
            a_v   = 1'b1;
            tok_a = make_tok(slb_pkg::KIND_ERROR, slb_pkg::OFFSET_W'(pend_start),
                             slb_pkg::OUTLEN_W'(pend_len), pend_line, pend_first,
                             slb_pkg::ERR_UNKNOWN);
          end
          slb_pkg::MODE_IDENT: begin
            a_v   = 1'b1;
            tok_a = make_tok(slb_pkg::KIND_IDENT, slb_pkg::OFFSET_W'(pend_start),
                             slb_pkg::OUTLEN_W'(pend_len), pend_line, pend_first,
                             slb_pkg::ERR_NONE);
          end
          default: begin
          end
        endcase
        b_v   = 1'b1;
        tok_b = make_tok(slb_pkg::KIND_END, slb_pkg::OFFSET_W'(pos), '0, line, 8'h00,
                         slb_pkg::ERR_NONE);
        mode_next       = slb_pkg::MODE_IDLE;
        pos_next        = '0;
        line_next       = slb_pkg::LINE_W'(1);
        pend_start_next = '0;
        pend_len_next   = '0;
        pend_line_next  = slb_pkg::LINE_W'(1);
        pend_first_next = '0;
        kprog_next      = slb_pkg::KP_NONE;
      end else begin
        pos_next = pos + POSITION_BITS'(1);
        if (in_byte == slb_pkg::CH_NEWLINE && line != '1) begin
          line_next = line + slb_pkg::LINE_W'(1);
        end

        unique case (mode)
          slb_pkg::MODE_COMMENT: begin
            if (in_byte == slb_pkg::CH_NEWLINE) begin
              mode_next = slb_pkg::MODE_IDLE;
            end
          end
          slb_pkg::MODE_STRING: begin
            if (in_byte == slb_pkg::CH_QUOTE) begin
              a_v       = 1'b1;
              tok_a     = make_tok(slb_pkg::KIND_STRING, slb_pkg::OFFSET_W'(pend_start),
                                   slb_pkg::OUTLEN_W'(len_inc), pend_line, pend_first,
                                   slb_pkg::ERR_NONE);
              mode_next = slb_pkg::MODE_IDLE;
            end else if (in_byte == slb_pkg::CH_NEWLINE) begin
              a_v       = 1'b1;
              tok_a     = make_tok(slb_pkg::KIND_ERROR, slb_pkg::OFFSET_W'(pend_start),
                                   slb_pkg::OUTLEN_W'(pend_len), pend_line, pend_first,
                                   slb_pkg::ERR_STRING_NEWLINE);
              mode_next = slb_pkg::MODE_ERROR;
            end else begin
              pend_len_next = len_inc;
            end
          end
          slb_pkg::MODE_INT: begin
            if (slb_pkg::is_digit(in_byte)) begin
              pend_len_next = len_inc;
            end else begin
              a_v       = 1'b1;
              tok_a     = make_tok(slb_pkg::KIND_INT, slb_pkg::OFFSET_W'(pend_start),
                                   slb_pkg::OUTLEN_W'(pend_len), pend_line, pend_first,
                                   slb_pkg::ERR_NONE);
              from_idle = 1'b1;
            end
          end
          slb_pkg::MODE_MINUS: begin
            if (slb_pkg::is_digit(in_byte)) begin
              pend_len_next = len_inc;
              mode_next     = slb_pkg::MODE_INT;
            end else begin
              // lone minus, the byte after it is dropped
              a_v       = 1'b1;
              tok_a     = make_tok(slb_pkg::KIND_ERROR, slb_pkg::OFFSET_W'(pend_start),
                                   slb_pkg::OUTLEN_W'(pend_len), pend_line, pend_first,
                                   slb_pkg::ERR_UNKNOWN);
              mode_next = slb_pkg::MODE_ERROR;
            end
          end
          slb_pkg::MODE_IDENT: begin
            if (slb_pkg::is_digit(in_byte) || slb_pkg::is_alpha(in_byte)) begin
              pend_len_next = len_inc;
              if (kprog == slb_pkg::KP_V && in_byte == slb_pkg::CH_A) begin
                kprog_next = slb_pkg::KP_VA;
              end else if (kprog == slb_pkg::KP_VA && in_byte == slb_pkg::CH_R) begin
                kprog_next = slb_pkg::KP_VAR;
              end else begin
                kprog_next = slb_pkg::KP_NONE;
              end
            end else begin
              a_v        = 1'b1;
              tok_a      = make_tok((kprog == slb_pkg::KP_VAR) ? slb_pkg::KIND_KEYWORD
                                                                : slb_pkg::KIND_IDENT,
                                    slb_pkg::OFFSET_W'(pend_start),
                                    slb_pkg::OUTLEN_W'(pend_len), pend_line, pend_first,
                                    slb_pkg::ERR_NONE);
              kprog_next = slb_pkg::KP_NONE;
              from_idle  = 1'b1;
            end
          end
          slb_pkg::MODE_ERROR: begin
          end
          default: begin
            from_idle = 1'b1;
          end
        endcase

        // start of a new token
        if (from_idle) begin
          mode_next = slb_pkg::MODE_IDLE;
          if (slb_pkg::is_space(in_byte)) begin
          end else if (in_byte == slb_pkg::CH_HASH) begin
            mode_next = slb_pkg::MODE_COMMENT;
          end else if (slb_pkg::is_op(in_byte)) begin
            b_v   = 1'b1;
            tok_b = make_tok(slb_pkg::KIND_OP, slb_pkg::OFFSET_W'(pos),
                             slb_pkg::OUTLEN_W'(1), line, in_byte, slb_pkg::ERR_NONE);
          end else if (in_byte == slb_pkg::CH_QUOTE || slb_pkg::is_digit(in_byte) ||
                       in_byte == slb_pkg::CH_MINUS || slb_pkg::is_alpha(in_byte)) begin
            pend_start_next = pos;
            pend_len_next   = LEN_W'(1);
            pend_line_next  = line;
            pend_first_next = in_byte;
            if (in_byte == slb_pkg::CH_QUOTE) begin
              mode_next = slb_pkg::MODE_STRING;
            end else if (slb_pkg::is_digit(in_byte)) begin
              mode_next = slb_pkg::MODE_INT;
            end else if (in_byte == slb_pkg::CH_MINUS) begin
              mode_next = slb_pkg::MODE_MINUS;
            end else begin
              mode_next  = slb_pkg::MODE_IDENT;
              kprog_next = (in_byte == slb_pkg::CH_V) ? slb_pkg::KP_V : slb_pkg::KP_NONE;
            end
          end else begin
            b_v       = 1'b1;
            tok_b     = make_tok(slb_pkg::KIND_ERROR, slb_pkg::OFFSET_W'(pos),
                                 slb_pkg::OUTLEN_W'(1), line, in_byte,
                                 slb_pkg::ERR_UNKNOWN);
            mode_next = slb_pkg::MODE_ERROR;
          end
        end
      end
    end

    if (b_v) begin
      tok_b.last_of_run = 1'b1;
    end else begin
      tok_a.last_of_run = 1'b1;
    end
  end

  assign res_count = {1'b0, a_v} + {1'b0, b_v};
  assign res0      = a_v ? tok_a : tok_b;
  assign res1      = tok_b;

endmodule

[rtl/slb_result_fifo.sv]
`timescale 1ns / 1ps

module slb_result_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      wr_count,
  input  slb_pkg::token_t wr0,
  input  slb_pkg::token_t wr1,
  output logic            room,
  output logic            rd_valid,
  input  logic            rd_ready,
  output slb_pkg::token_t rd_data
);

  slb_pkg::token_t              buf_q [slb_pkg::FIFO_DEPTH];
  logic [slb_pkg::FIFO_AW-1:0]  wp, rp;
  logic [slb_pkg::FIFO_AW:0]    count;
  logic                         pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count != '0);
  assign rd_data  = buf_q[rp];
  // two free entries so that a byte giving two tokens always fits
  assign room     = (count <= (slb_pkg::FIFO_AW + 1)'(slb_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      buf_q[wp] <= wr0;
    end
    if (wr_count == 2'd2) begin
      buf_q[wp + slb_pkg::FIFO_AW'(1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + slb_pkg::FIFO_AW'(wr_count);
      if (pop) begin
        rp <= rp + slb_pkg::FIFO_AW'(1);
      end
      count <= count + (slb_pkg::FIFO_AW + 1)'(wr_count)
                     - (slb_pkg::FIFO_AW + 1)'(pop);
    end
  end

endmodule
